/* rtl/core/cursor_overlay_alpha_blend_assert.svh */
// Assertion macros shared by the cursor overlay RTL.
`ifndef CURSOR_OVERLAY_ALPHA_BLEND_ASSERT_SVH
`define CURSOR_OVERLAY_ALPHA_BLEND_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define COAB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define COAB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/coab_pkg.sv */
// Shared types, constants and helper functions for the cursor overlay.
package coab_pkg;

	localparam int CURSOR_SIDE = 64;
	localparam int SIDE_BITS   = $clog2(CURSOR_SIDE);
	localparam int STORE_DEPTH = CURSOR_SIDE * CURSOR_SIDE;
	localparam int STORE_BITS  = 2 * SIDE_BITS;
	localparam int FRAME_SIDE  = 4096;
	localparam int COORD_BITS  = 12;
	localparam int POS_BITS    = 13;
	localparam int DIM_BITS    = 7;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 13;

	localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TOP    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 3'd4;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

	typedef struct packed {
		logic                       enable;
		logic signed [POS_BITS-1:0] left;
		logic signed [POS_BITS-1:0] top;
		logic [DIM_BITS-1:0]        width;
		logic [DIM_BITS-1:0]        height;
	} cfg_t;

	// Colour channels are ordered blue, green, red as in the pixel word.
	typedef logic [2:0][7:0] rgb_t;

	typedef struct packed {
		logic        hit;
		rgb_t        colour;
		logic [7:0]  fourth;
	} pix_t;

	// Exact floor(x / 255) for any x below 65280, where the quotient fits in 8 bits.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'(x[15:8]) + 17'd1;
		return t[15:8];
	endfunction

	// Clamp a requested cursor side to the size of the image store.
	function automatic logic [DIM_BITS-1:0] sat_side(input logic [DIM_BITS-1:0] v);
		return (v > DIM_BITS'(CURSOR_SIDE)) ? DIM_BITS'(CURSOR_SIDE) : v;
	endfunction

endpackage

/* rtl/core/coab_cfg.sv */
// Configuration register file for the cursor overlay.
module coab_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	input  logic [coab_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [coab_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output coab_pkg::cfg_t                        cfg
);

	coab_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				coab_pkg::CFG_ENABLE: cfg_q.enable <= cfg_data[0];
				coab_pkg::CFG_LEFT:   cfg_q.left   <= $signed(cfg_data);
				coab_pkg::CFG_TOP:    cfg_q.top    <= $signed(cfg_data);
				coab_pkg::CFG_WIDTH:  cfg_q.width  <=
					coab_pkg::sat_side(cfg_data[coab_pkg::DIM_BITS-1:0]);
				coab_pkg::CFG_HEIGHT: cfg_q.height <=
					coab_pkg::sat_side(cfg_data[coab_pkg::DIM_BITS-1:0]);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/core/coab_fetch.sv */
// Cursor rectangle hit test and cursor image store with registered read.
module coab_fetch (
	input  logic                                clk,
	input  logic                                arst_n,
	input  coab_pkg::cfg_t                      cfg,
	input  logic                                adv,
	input  logic                                in_valid,
	input  logic                                command,
	input  logic [coab_pkg::COORD_BITS-1:0]     cursor_index,
	input  logic [31:0]                         cursor_argb,
	input  logic [coab_pkg::COORD_BITS-1:0]     pixel_x,
	input  logic [coab_pkg::COORD_BITS-1:0]     pixel_y,
	input  logic [7:0]                          pixel_blue,
	input  logic [7:0]                          pixel_green,
	input  logic [7:0]                          pixel_red,
	input  logic [7:0]                          pixel_fourth,
	output logic                                valid_s1,
	output coab_pkg::pix_t                      pix_s1,
	output logic [31:0]                         word_s1
);

	localparam int DW = coab_pkg::POS_BITS + 1;

	logic [31:0] store_q [coab_pkg::STORE_DEPTH];

	logic signed [DW-1:0] col, row;
	logic                 in_frame, hit;
	logic [coab_pkg::STORE_BITS-1:0] rd_idx;
	logic                 accept;

	assign accept = in_valid && adv;

	always_comb begin
		col = $signed(DW'(pixel_x)) - DW'(cfg.left);
		row = $signed(DW'(pixel_y)) - DW'(cfg.top);
		in_frame = (DW'(pixel_x) < DW'(coab_pkg::FRAME_SIDE)) &&
			(DW'(pixel_y) < DW'(coab_pkg::FRAME_SIDE));
		hit = cfg.enable && in_frame && !col[DW-1] && !row[DW-1] &&
			(col[DW-2:0] < (DW-1)'(cfg.width)) &&
			(row[DW-2:0] < (DW-1)'(cfg.height));
		rd_idx = {row[coab_pkg::SIDE_BITS-1:0], col[coab_pkg::SIDE_BITS-1:0]};
	end

	// One item per edge, taken only while the stage advances, so a load and a pixel never touch the store together.
	always_ff @(posedge clk) begin
		if (accept && !command) begin
			store_q[cursor_index[coab_pkg::STORE_BITS-1:0]] <= cursor_argb;
		end
		if (adv) begin
			word_s1 <= store_q[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1.hit    <= hit;
			pix_s1.colour <= {pixel_red, pixel_green, pixel_blue};
			pix_s1.fourth <= pixel_fourth;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid && command;
		end
	end

endmodule

/* rtl/core/coab_blend.sv */
// Alpha blend: products and sums in one stage, divide by 255 and select in the next.
module coab_blend (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  coab_pkg::pix_t     pix_s1,
	input  logic [31:0]        word_s1,
	input  logic               out_stall,
	output logic               adv_s1,
	output logic               out_valid,
	output logic [7:0]         out_blue,
	output logic [7:0]         out_green,
	output logic [7:0]         out_red,
	output logic [7:0]         out_fourth
);

	logic                 valid_s2, valid_s3;
	logic                 adv_s2, adv_s3;
	logic                 mix_s2;
	coab_pkg::rgb_t       byte_s2;
	logic [2:0][15:0]     sum_s2;
	logic [7:0]           fourth_s2;
	coab_pkg::rgb_t       res_s3;
	logic [7:0]           fourth_s3;

	logic [7:0]           alpha;
	coab_pkg::rgb_t       cur;
	logic [2:0][15:0]     sum;
	coab_pkg::rgb_t       pass;
	logic                 mix;
	coab_pkg::rgb_t       res;

	assign adv_s3 = !valid_s3 || !out_stall;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;

	always_comb begin
		alpha = word_s1[31:24];
		cur   = word_s1[23:0];
		for (int i = 0; i < 3; i++) begin
			sum[i] = 16'(cur[i]) * 16'(alpha) +
				16'(pix_s1.colour[i]) * 16'(coab_pkg::ALPHA_OPAQUE - alpha);
		end
		mix  = pix_s1.hit && (alpha != coab_pkg::ALPHA_OPAQUE) &&
			(alpha != coab_pkg::ALPHA_CLEAR);
		pass = (pix_s1.hit && (alpha == coab_pkg::ALPHA_OPAQUE)) ? cur : pix_s1.colour;
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			mix_s2    <= mix;
			byte_s2   <= pass;
			sum_s2    <= sum;
			fourth_s2 <= pix_s1.fourth;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			res[i] = mix_s2 ? coab_pkg::div255(sum_s2[i]) : byte_s2[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			res_s3    <= res;
			fourth_s3 <= fourth_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	assign out_valid  = valid_s3;
	assign out_blue   = res_s3[0];
	assign out_green  = res_s3[1];
	assign out_red    = res_s3[2];
	assign out_fourth = fourth_s3;

endmodule

/* rtl/core/cursor_overlay_alpha_blend.sv */
// Top level of the hardware cursor overlay on a BGRA pixel stream.
//
// Input channel (in_valid / in_stall): each item is either a cursor load
// (command low), which writes cursor_argb into the 64 x 64 cursor image store
// at cursor_index and gives no result, or a frame pixel (command high), which
// gives exactly one result item on the output channel.
// Output channel (out_valid / out_stall): carries the composited B, G and R
// bytes and the untouched fourth byte, in the order the pixels arrived.
// Configuration (cfg_valid / cfg_ready): cfg_ready is always high; registers
// are enable, left, top, width and height, and should be written while idle.
// Width and height above 64 are clamped to 64 on write.
// Throughput is one item per clock while the receiver does not stall. A pixel
// passes three registers (store read, blend products, divide by 255 and select)
// before its result is on the output. The latency is set by the registered read
// of the image store, the multiplier stage ahead of the divide and the register
// after the divide.
// When the receiver stalls, each stage keeps moving until it meets a full stage
// behind it, so bubbles close up and in_stall rises only once all three stages
// hold items. Reset clears the valid bits and the configuration registers
// (compositing off); the image store is not cleared and must be loaded first.
module cursor_overlay_alpha_blend (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                command,
	input  logic [coab_pkg::COORD_BITS-1:0]     cursor_index,
	input  logic [31:0]                         cursor_argb,
	input  logic [coab_pkg::COORD_BITS-1:0]     pixel_x,
	input  logic [coab_pkg::COORD_BITS-1:0]     pixel_y,
	input  logic [7:0]                          pixel_blue,
	input  logic [7:0]                          pixel_green,
	input  logic [7:0]                          pixel_red,
	input  logic [7:0]                          pixel_fourth,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          out_blue,
	output logic [7:0]                          out_green,
	output logic [7:0]                          out_red,
	output logic [7:0]                          out_fourth,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [coab_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [coab_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

`include "cursor_overlay_alpha_blend_assert.svh"

	coab_pkg::cfg_t cfg;
	logic           adv_s1;
	logic           valid_s1;
	coab_pkg::pix_t pix_s1;
	logic [31:0]    word_s1;

	// Registers accept every write at once.
	assign cfg_ready = 1'b1;

	// The first stage can take an item whenever it is empty or will drain.
	assign in_stall = !adv_s1;

	coab_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	coab_fetch u_fetch (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.adv          (adv_s1),
		.in_valid     (in_valid),
		.command      (command),
		.cursor_index (cursor_index),
		.cursor_argb  (cursor_argb),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_blue   (pixel_blue),
		.pixel_green  (pixel_green),
		.pixel_red    (pixel_red),
		.pixel_fourth (pixel_fourth),
		.valid_s1     (valid_s1),
		.pix_s1       (pix_s1),
		.word_s1      (word_s1)
	);

	coab_blend u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.pix_s1     (pix_s1),
		.word_s1    (word_s1),
		.out_stall  (out_stall),
		.adv_s1     (adv_s1),
		.out_valid  (out_valid),
		.out_blue   (out_blue),
		.out_green  (out_green),
		.out_red    (out_red),
		.out_fourth (out_fourth)
	);

	// The input may only be held off when a full result is held at the output.
	`COAB_ASSERT_IMP(a_stall_only_when_full, in_stall, out_valid && out_stall, "in_stall without a stalled result")
	// An accepted pixel always occupies the first stage on the next cycle.
	`COAB_ASSERT_NXT(a_pixel_enters, in_valid && !in_stall && command, valid_s1, "accepted pixel lost")
	// A cursor load never turns into a result item.
	`COAB_ASSERT_NXT(a_load_no_result, in_valid && !in_stall && !command, !valid_s1, "load produced a result")

endmodule

/* verif/tb_cursor_overlay_alpha_blend.sv */
// Self-checking testbench for the cursor overlay: directed and random traffic against a predictor.
`timescale 1ns / 100ps

module tb_cursor_overlay_alpha_blend;

	// Sizes taken over from the design package.
	localparam int COORD_BITS    = coab_pkg::COORD_BITS;
	localparam int CFG_IDX_BITS  = coab_pkg::CFG_IDX_BITS;
	localparam int CFG_DATA_BITS = coab_pkg::CFG_DATA_BITS;
	localparam int STORE_DEPTH   = coab_pkg::STORE_DEPTH;
	localparam int CURSOR_SIDE   = coab_pkg::CURSOR_SIDE;
	localparam int FRAME_SIDE    = coab_pkg::FRAME_SIDE;

	// The two kinds of input item.
	localparam bit CMD_LOAD  = 1'b0;
	localparam bit CMD_PIXEL = 1'b1;

	// The pause before a register write and at the end lets every pixel drain out of
	// the pipeline with a comfortable margin.
	localparam int DRAIN_CYCLES = 12;
	// Sender gaps and receiver stalls stay far shorter than QUIET_LIMIT, so that
	// long a spell with nothing moving can only mean the block has hung.
	localparam int QUIET_LIMIT = 1000;
	localparam int MISMATCH_REPORTS = 10;
	localparam int RANDOM_PHASES = 8;
	localparam int RANDOM_ITEMS_PER_PHASE = 205;

	typedef struct {
		bit                  cmd;
		bit [COORD_BITS-1:0] index;
		bit [31:0]           argb;
		bit [COORD_BITS-1:0] x;
		bit [COORD_BITS-1:0] y;
		bit [7:0]            blue;
		bit [7:0]            green;
		bit [7:0]            red;
		bit [7:0]            fourth;
	} overlay_item_t;

	typedef struct packed {
		bit [7:0] blue;
		bit [7:0] green;
		bit [7:0] red;
		bit [7:0] fourth;
	} bgra_t;

	// Every input of the block starts at a known value, with reset asserted.
	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     command = CMD_LOAD;
	logic [COORD_BITS-1:0]    cursor_index = '0;
	logic [31:0]              cursor_argb = '0;
	logic [COORD_BITS-1:0]    pixel_x = '0;
	logic [COORD_BITS-1:0]    pixel_y = '0;
	logic [7:0]               pixel_blue = '0;
	logic [7:0]               pixel_green = '0;
	logic [7:0]               pixel_red = '0;
	logic [7:0]               pixel_fourth = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [7:0]               out_blue;
	logic [7:0]               out_green;
	logic [7:0]               out_red;
	logic [7:0]               out_fourth;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	// The predictor's own copy of the registers and of the cursor image store.
	bit        view_enable;
	int        view_left;
	int        view_top;
	int        view_width;
	int        view_height;
	bit [31:0] cursor_words [STORE_DEPTH];
	bit        word_loaded [STORE_DEPTH];

	// Composited pixels still owed by the block, oldest first.
	bgra_t expected_pixels [$];

	int error_count = 0;
	int quiet_cycles = 0;
	int burst_left = 0;
	int items_sent = 0;
	bit sender_eager = 1'b0;

	cursor_overlay_alpha_blend dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.cursor_index (cursor_index),
		.cursor_argb  (cursor_argb),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_blue   (pixel_blue),
		.pixel_green  (pixel_green),
		.pixel_red    (pixel_red),
		.pixel_fourth (pixel_fourth),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_blue     (out_blue),
		.out_green    (out_green),
		.out_red      (out_red),
		.out_fourth   (out_fourth),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void report_failure(input string what);
		error_count++;
		if (error_count <= MISMATCH_REPORTS) begin
			$display("ERROR at %0t: %s", $time, what);
		end
	endfunction

	// Mirrors a register write. Enable keeps its lowest bit, the corner is a
	// 13-bit signed value and the sides keep seven bits, clamped to the store side.
	// Writes to the spare indexes change nothing.
	function automatic void shadow_register(input logic [CFG_IDX_BITS-1:0] index,
			input logic [CFG_DATA_BITS-1:0] data);
		int side;
		side = (int'(data[6:0]) > CURSOR_SIDE) ? CURSOR_SIDE : int'(data[6:0]);
		case (index)
			coab_pkg::CFG_ENABLE: view_enable = data[0];
			coab_pkg::CFG_LEFT:   view_left = $signed(data);
			coab_pkg::CFG_TOP:    view_top = $signed(data);
			coab_pkg::CFG_WIDTH:  view_width = side;
			coab_pkg::CFG_HEIGHT: view_height = side;
			default: ;
		endcase
	endfunction

	// Tells whether a frame pixel falls under the cursor, and which store entry covers it.
	function automatic bit cursor_entry(input bit [COORD_BITS-1:0] x,
			input bit [COORD_BITS-1:0] y, output int entry);
		int col;
		int row;
		col = int'(x) - view_left;
		row = int'(y) - view_top;
		entry = row * CURSOR_SIDE + col;
		return view_enable && col >= 0 && row >= 0 && col < view_width && row < view_height;
	endfunction

	function automatic bit [7:0] blend_channel(input int cursor_byte, input int frame_byte,
			input int alpha);
		return 8'((cursor_byte * alpha + frame_byte * (255 - alpha)) / 255);
	endfunction

	// The pixel the block should give back: untouched outside the cursor or under a
	// clear word, replaced under an opaque one, blended and truncated otherwise.
	function automatic bgra_t composite_pixel(input overlay_item_t it);
		bgra_t     px;
		int        entry;
		bit [31:0] word;
		int        alpha;
		px = '{blue: it.blue, green: it.green, red: it.red, fourth: it.fourth};
		if (cursor_entry(it.x, it.y, entry)) begin
			word = cursor_words[entry];
			alpha = word[31:24];
			if (alpha == coab_pkg::ALPHA_OPAQUE) begin
				px.blue = word[7:0];
				px.green = word[15:8];
				px.red = word[23:16];
			end else if (alpha != coab_pkg::ALPHA_CLEAR) begin
				px.blue = blend_channel(word[7:0], it.blue, alpha);
				px.green = blend_channel(word[15:8], it.green, alpha);
				px.red = blend_channel(word[23:16], it.red, alpha);
			end
		end
		return px;
	endfunction

	// Cursor words lean towards the two special alphas, clear and opaque.
	function automatic bit [31:0] random_word();
		bit [7:0] alpha;
		case ($urandom_range(0, 3))
			0: alpha = coab_pkg::ALPHA_CLEAR;
			1: alpha = coab_pkg::ALPHA_OPAQUE;
			default: alpha = 8'($urandom_range(0, 255));
		endcase
		return {alpha, 24'($urandom())};
	endfunction

	// The fields that an item's kind ignores carry random junk.
	function automatic overlay_item_t make_load(input int index, input bit [31:0] argb);
		overlay_item_t it;
		it.cmd = CMD_LOAD;
		it.index = COORD_BITS'(index);
		it.argb = argb;
		it.x = COORD_BITS'($urandom());
		it.y = COORD_BITS'($urandom());
		it.blue = 8'($urandom());
		it.green = 8'($urandom());
		it.red = 8'($urandom());
		it.fourth = 8'($urandom());
		return it;
	endfunction

	function automatic overlay_item_t make_pixel(input int x, input int y, input bit [7:0] blue,
			input bit [7:0] green, input bit [7:0] red, input bit [7:0] fourth);
		overlay_item_t it;
		it.cmd = CMD_PIXEL;
		it.index = COORD_BITS'($urandom());
		it.argb = $urandom();
		it.x = COORD_BITS'(x);
		it.y = COORD_BITS'(y);
		it.blue = blue;
		it.green = green;
		it.red = red;
		it.fourth = fourth;
		return it;
	endfunction

	// Offers one item and waits until the block takes it, then lets the predictor see it.
	// The sender works in bursts; between bursts, unless eager, it sometimes drops valid.
	// Valid is left high on return so that the next item can follow without a bubble.
	task automatic send_item(input overlay_item_t it);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			if (!sender_eager && $urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		command <= it.cmd;
		cursor_index <= it.index;
		cursor_argb <= it.argb;
		pixel_x <= it.x;
		pixel_y <= it.y;
		pixel_blue <= it.blue;
		pixel_green <= it.green;
		pixel_red <= it.red;
		pixel_fourth <= it.fourth;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		if (it.cmd == CMD_LOAD) begin
			cursor_words[it.index] = it.argb;
			word_loaded[it.index] = 1'b1;
		end else begin
			expected_pixels.push_back(composite_pixel(it));
		end
	endtask

	task automatic send_load(input int index, input bit [31:0] argb);
		send_item(make_load(index, argb));
	endtask

	// A pixel that would read a store entry never loaded is preceded by a load of it,
	// since such a read has no defined answer.
	task automatic send_pixel(input int x, input int y, input bit [7:0] blue,
			input bit [7:0] green, input bit [7:0] red, input bit [7:0] fourth);
		int entry;
		if (cursor_entry(COORD_BITS'(x), COORD_BITS'(y), entry) && !word_loaded[entry]) begin
			send_load(entry, random_word());
		end
		send_item(make_pixel(x, y, blue, green, red, fourth));
	endtask

	// Drops valid, waits for every owed pixel, then lets the pipeline settle so that
	// a trailing load has landed before anything is reconfigured.
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register write; valid stays high so that writes can run back to back.
	task automatic write_register(input logic [CFG_IDX_BITS-1:0] index,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		shadow_register(index, data);
	endtask

	// Writes all five registers, junk in the unused bits of enable, and optionally a
	// spare index which must be ignored.
	task automatic program_cursor(input bit enable, input int left, input int top,
			input int width_data, input int height_data, input bit spare);
		write_register(coab_pkg::CFG_ENABLE, {12'($urandom()), enable});
		write_register(coab_pkg::CFG_LEFT, CFG_DATA_BITS'(left));
		write_register(coab_pkg::CFG_TOP, CFG_DATA_BITS'(top));
		write_register(coab_pkg::CFG_WIDTH, CFG_DATA_BITS'(width_data));
		write_register(coab_pkg::CFG_HEIGHT, CFG_DATA_BITS'(height_data));
		if (spare) begin
			write_register(CFG_IDX_BITS'($urandom_range(coab_pkg::CFG_HEIGHT + 1,
				(1 << CFG_IDX_BITS) - 1)), CFG_DATA_BITS'($urandom()));
		end
		cfg_valid <= 1'b0;
	endtask

	// Straight out of reset compositing is off and the cursor has no size, so every
	// pixel comes back as it went in; loads give nothing back.
	task automatic test_reset_passthrough();
		send_pixel(0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
		send_load(STORE_DEPTH - 1, {coab_pkg::ALPHA_OPAQUE, 24'h3C5A96});
		send_load(0, {coab_pkg::ALPHA_OPAQUE, 24'hC0FFEE});
		send_pixel(4095, 4095, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(2048, 1, 8'h55, 8'hAA, 8'h0F, 8'hF0);
	endtask

	// A one-row cursor with one word of each kind of alpha: clear, opaque, the
	// smallest and largest partial values and a middle one. Pixels just outside
	// each edge must pass untouched.
	task automatic test_blend_rules();
		wait_idle();
		program_cursor(1'b1, 100, 200, 5, 1, 1'b0);
		send_load(0, {coab_pkg::ALPHA_CLEAR, 24'h123456});
		send_load(1, {coab_pkg::ALPHA_OPAQUE, 24'hA1B2C3});
		send_load(2, {8'd1, 24'hFF00FF});
		send_load(3, {8'd128, 24'h00FF80});
		send_load(4, {8'd254, 24'h0000FF});
		send_pixel(100, 200, 8'h00, 8'hFF, 8'h7F, 8'h5A);
		send_pixel(101, 200, 8'hFF, 8'h00, 8'h80, 8'hA5);
		send_pixel(102, 200, 8'h00, 8'hFF, 8'h00, 8'h00);
		send_pixel(103, 200, 8'hFF, 8'h00, 8'h01, 8'hFF);
		send_pixel(104, 200, 8'hFF, 8'hFF, 8'h00, 8'h3C);
		send_pixel(99, 200, 8'h11, 8'h22, 8'h33, 8'h44);
		send_pixel(105, 200, 8'h55, 8'h66, 8'h77, 8'h88);
		send_pixel(100, 199, 8'h99, 8'hAA, 8'hBB, 8'hCC);
		send_pixel(100, 201, 8'hDD, 8'hEE, 8'hFF, 8'h00);
	endtask

	// Register extremes: sides written above the store size clamp to it, the corner
	// at both ends of its signed range, a zero width, and writes to spare indexes.
	task automatic test_register_extremes();
		wait_idle();
		program_cursor(1'b1, -63, -63, 13'h1FFF, 13'h0041, 1'b1);
		send_pixel(0, 0, 8'h12, 8'h34, 8'h56, 8'h78);
		send_pixel(63, 63, 8'h9A, 8'hBC, 8'hDE, 8'hF0);
		wait_idle();
		program_cursor(1'b1, 4095, 4095, 64, 64, 1'b1);
		send_pixel(4095, 4095, 8'h00, 8'h00, 8'h00, 8'h00);
		send_pixel(4094, 4095, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		wait_idle();
		program_cursor(1'b1, -4096, -4096, 64, 64, 1'b0);
		send_pixel(0, 0, 8'hA5, 8'h5A, 8'hC3, 8'h3C);
		wait_idle();
		program_cursor(1'b1, 0, 0, 0, 64, 1'b0);
		send_pixel(0, 0, 8'h01, 8'h02, 8'h04, 8'h08);
	endtask

	// Random items under the current settings. Most pixels land on or just around
	// the cursor so the blend is exercised; the rest roam the whole frame. Loads
	// rewrite words under the cursor or anywhere in the store. The count includes
	// the loads that go ahead of pixels on fresh entries.
	task automatic run_random_phase(input int item_count);
		int pick;
		int x;
		int y;
		int span_w;
		int span_h;
		int first;
		first = items_sent;
		while (items_sent - first < item_count) begin
			pick = $urandom_range(0, 9);
			span_w = (view_width > 0) ? view_width : 1;
			span_h = (view_height > 0) ? view_height : 1;
			if (pick < 7) begin
				x = view_left + int'($urandom_range(0, span_w + 3)) - 2;
				y = view_top + int'($urandom_range(0, span_h + 3)) - 2;
				if (x < 0 || x >= FRAME_SIDE) x = $urandom_range(0, FRAME_SIDE - 1);
				if (y < 0 || y >= FRAME_SIDE) y = $urandom_range(0, FRAME_SIDE - 1);
				send_pixel(x, y, 8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
			end else if (pick < 9) begin
				send_pixel($urandom_range(0, FRAME_SIDE - 1), $urandom_range(0, FRAME_SIDE - 1),
					8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
			end else if ($urandom_range(0, 1) == 0) begin
				send_load(int'($urandom_range(0, span_h - 1)) * CURSOR_SIDE
					+ int'($urandom_range(0, span_w - 1)), random_word());
			end else begin
				send_load($urandom_range(0, STORE_DEPTH - 1), random_word());
			end
		end
	endtask

	// Several settings in turn, the corners of the frame and the degenerate ones
	// among them. Every third phase the sender never pauses.
	task automatic test_random_traffic();
		int left;
		int top;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_idle();
			left = int'($urandom_range(0, 140)) - 70;
			top = int'($urandom_range(0, 140)) - 70;
			case (phase)
				0: program_cursor(1'b1, left, top, $urandom_range(1, 64), $urandom_range(1, 64), 1'b0);
				1: program_cursor(1'b1, 4095 - int'($urandom_range(0, 63)),
					4095 - int'($urandom_range(0, 63)), 64, 64, 1'b1);
				2: program_cursor(1'b0, left, top, $urandom_range(1, 64), $urandom_range(1, 64), 1'b0);
				3: program_cursor(1'b1, -4096, 4095, $urandom_range(65, 127), $urandom(), 1'b1);
				4: program_cursor(1'b1, left, top, 0, $urandom_range(1, 64), 1'b0);
				5: program_cursor(1'b1, -63, -63, 64, 64, 1'b1);
				default: begin
					if ($urandom_range(0, 3) == 0) begin
						left = int'($urandom_range(0, 8191)) - 4096;
						top = int'($urandom_range(0, 8191)) - 4096;
					end
					program_cursor(1'b1, left, top, $urandom(), $urandom(), phase[0]);
				end
			endcase
			sender_eager = (phase % 3 == 2);
			run_random_phase(RANDOM_ITEMS_PER_PHASE);
		end
		sender_eager = 1'b0;
	endtask

	// The receiver switches between a few stall habits: none at all, light and heavy
	// random stalls, and a fixed duty pattern that holds the output on most beats.
	initial begin : receiver_stall_pattern
		int habit;
		int span;
		int beat;
		forever begin
			habit = $urandom_range(0, 3);
			span = $urandom_range(20, 150);
			for (beat = 0; beat < span; beat++) begin
				@(posedge clk);
				case (habit)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ((beat % 8) < 5);
				endcase
			end
		end
	end

	// Each result taken from the block is checked against the oldest owed pixel.
	always @(posedge clk) begin : pixel_checker
		bgra_t want;
		bgra_t got;
		string wrong;
		if (arst_n && out_valid && !out_stall) begin
			got = '{blue: out_blue, green: out_green, red: out_red, fourth: out_fourth};
			if (expected_pixels.size() == 0) begin
				report_failure($sformatf("result with nothing owed: b=%02h g=%02h r=%02h f=%02h",
					got.blue, got.green, got.red, got.fourth));
			end else begin
				want = expected_pixels.pop_front();
				wrong = "";
				if (got.blue != want.blue) wrong = {wrong, " blue"};
				if (got.green != want.green) wrong = {wrong, " green"};
				if (got.red != want.red) wrong = {wrong, " red"};
				if (got.fourth != want.fourth) wrong = {wrong, " fourth"};
				if (wrong != "") begin
					report_failure($sformatf(
						"mismatch in%s: expected bgrf %02h %02h %02h %02h, got %02h %02h %02h %02h",
						wrong, want.blue, want.green, want.red, want.fourth,
						got.blue, got.green, got.red, got.fourth));
				end
			end
		end
	end

	// Ends the run if nothing at all is taken on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_passthrough();
		test_blend_rules();
		test_register_extremes();
		test_random_traffic();
		wait_idle();
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
